FILE: sv/bpdrq_pkg.sv
// ============================================================================
// bpdrq_pkg
// Shared types, codes and defaults of the bounded priority drop/retry queue.
// ============================================================================
package bpdrq_pkg;

    localparam int DEPTH_DEFAULT    = 32;
    localparam int TAG_BITS_DEFAULT = 16;

    localparam int OP_W        = 2;
    localparam int FIELD_TAG_W = 16;
    localparam int PRIO_W      = 16;
    localparam int RETRY_W     = 4;
    localparam int EVENT_W     = 3;
    localparam int QCOUNT_W    = 6;
    localparam int CFG_DATA_W  = 6;
    localparam int CFG_INDEX_W = 1;

    localparam logic [5:0] QUEUE_LIMIT_RESET = 6'd20;
    localparam logic [3:0] RETRY_LIMIT_RESET = 4'd1;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE  = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_COMPLETE = 2'd2
    } op_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_QUEUED     = 3'd0,
        EV_DISPATCHED = 3'd1,
        EV_NOTHING    = 3'd2,
        EV_SUCCESS    = 3'd3,
        EV_REQUEUED   = 3'd4,
        EV_GAVE_UP    = 3'd5,
        EV_IGNORED    = 3'd6
    } event_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_QUEUE_LIMIT = 1'd0,
        CFG_RETRY_LIMIT = 1'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_APPEND,
        S_FETCH,
        S_DONE
    } state_t;

endpackage

FILE: sv/bpdrq_req_if.sv
// ============================================================================
// bpdrq_req_if
// Request channel: valid/ready handshake plus one request item.
// ============================================================================
interface bpdrq_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [bpdrq_pkg::OP_W-1:0]             operation;
    logic [bpdrq_pkg::FIELD_TAG_W-1:0]      request_tag;
    logic signed [bpdrq_pkg::PRIO_W-1:0]    request_priority;
    logic [bpdrq_pkg::RETRY_W-1:0]          retries_used;
    logic                                   failed;
    logic                                   refused;

    modport source (
        output valid, operation, request_tag, request_priority, retries_used, failed, refused,
        input  ready
    );
    modport sink (
        input  valid, operation, request_tag, request_priority, retries_used, failed, refused,
        output ready
    );
endinterface

FILE: sv/bpdrq_rsp_if.sv
// ============================================================================
// bpdrq_rsp_if
// Response channel: valid/ready handshake plus one result item.
// ============================================================================
interface bpdrq_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic [bpdrq_pkg::EVENT_W-1:0]          event_res;
    logic [bpdrq_pkg::FIELD_TAG_W-1:0]      item_tag;
    logic                                   evicted;
    logic [bpdrq_pkg::FIELD_TAG_W-1:0]      evicted_tag;
    logic signed [bpdrq_pkg::PRIO_W-1:0]    evicted_priority;
    logic [bpdrq_pkg::QCOUNT_W-1:0]         queue_count;
    logic                                   connection_error;

    modport source (
        output valid, event_res, item_tag, evicted, evicted_tag, evicted_priority,
               queue_count, connection_error,
        input  ready
    );
    modport sink (
        input  valid, event_res, item_tag, evicted, evicted_tag, evicted_priority,
               queue_count, connection_error,
        output ready
    );
endinterface

FILE: sv/bpdrq_mem.sv
// ============================================================================
// bpdrq_mem
// Entry store: one write port, one read port, registered read data.
// ============================================================================
module bpdrq_mem #(
    parameter int DEPTH = bpdrq_pkg::DEPTH_DEFAULT,
    parameter int WIDTH = 36
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/bounded_priority_drop_retry_queue.sv
// ============================================================================
// bounded_priority_drop_retry_queue
// Request FIFO with lowest-priority eviction, one in-flight slot and retries.
//
// One item is worked at a time; request.ready is high only while the
// sequencer is idle, and the next item may be taken while the previous result
// still waits on the response channel. Entries live in a single-port-read
// ring buffer, so every pass over the queue reads its entries one at a time.
// An insert at the limit (enqueue or requeue) scans all N queued entries
// through one priority comparator, then moves the entries behind the evicted
// one down a slot.
// ============================================================================
module bounded_priority_drop_retry_queue #(
    parameter int QUEUE_DEPTH = bpdrq_pkg::DEPTH_DEFAULT,
    parameter int TAG_BITS    = bpdrq_pkg::TAG_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bpdrq_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bpdrq_pkg::CFG_DATA_W-1:0]    cfg_data,
    bpdrq_req_if.sink                           request,
    bpdrq_rsp_if.source                         response
);

    localparam int AW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int SW   = CW + 1;
    localparam int CMPW = (CW > 6) ? CW : 6;
    localparam int RW   = bpdrq_pkg::RETRY_W;
    localparam int PW   = bpdrq_pkg::PRIO_W;
    localparam int FTW  = bpdrq_pkg::FIELD_TAG_W;
    localparam int EW   = TAG_BITS + PW + RW;

    bpdrq_pkg::state_t state_reg, state_next;

    logic [AW-1:0]          head_reg, head_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   busy_reg, busy_next;
    logic [TAG_BITS-1:0]    flight_tag_reg, flight_tag_next;
    logic signed [PW-1:0]   flight_prio_reg, flight_prio_next;
    logic [RW-1:0]          flight_retries_reg, flight_retries_next;
    logic [5:0]             qlim_reg, qlim_next;
    logic [3:0]             rlim_reg, rlim_next;

    logic [TAG_BITS-1:0]    ins_tag_reg, ins_tag_next;
    logic signed [PW-1:0]   ins_prio_reg, ins_prio_next;
    logic [RW-1:0]          ins_retries_reg, ins_retries_next;

    logic [CW-1:0]          idx_reg, idx_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [CW-1:0]          rd_lidx_reg, rd_lidx_next;
    logic signed [PW-1:0]   min_prio_reg, min_prio_next;
    logic [CW-1:0]          min_lidx_reg, min_lidx_next;
    logic [TAG_BITS-1:0]    min_tag_reg, min_tag_next;

    bpdrq_pkg::event_t      res_event_reg, res_event_next;
    logic [FTW-1:0]         res_tag_reg, res_tag_next;
    logic                   res_evicted_reg, res_evicted_next;
    logic [FTW-1:0]         res_ev_tag_reg, res_ev_tag_next;
    logic signed [PW-1:0]   res_ev_prio_reg, res_ev_prio_next;
    logic                   res_conn_reg, res_conn_next;

    logic                   out_valid_reg, out_valid_next;
    bpdrq_pkg::event_t      out_event_reg, out_event_next;
    logic [FTW-1:0]         out_tag_reg, out_tag_next;
    logic                   out_evicted_reg, out_evicted_next;
    logic [FTW-1:0]         out_ev_tag_reg, out_ev_tag_next;
    logic signed [PW-1:0]   out_ev_prio_reg, out_ev_prio_next;
    logic [5:0]             out_count_reg, out_count_next;
    logic                   out_conn_reg, out_conn_next;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [EW-1:0]          mem_wdata;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;
    logic [EW-1:0]          mem_rdata;

    logic [TAG_BITS-1:0]    rd_tag;
    logic signed [PW-1:0]   rd_prio;
    logic [RW-1:0]          rd_retries;
    logic [TAG_BITS-1:0]    req_tag_m;
    logic [CMPW-1:0]        eff_limit;
    logic                   at_limit;
    logic                   take;
    logic                   out_load;

    // logical queue position -> ring buffer slot
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] i);
        logic [SW-1:0] sum;
        begin
            sum = SW'(head) + SW'(i);
            if (sum >= SW'(QUEUE_DEPTH))
            begin
                sum = sum - SW'(QUEUE_DEPTH);
            end
            return sum[AW-1:0];
        end
    endfunction

    bpdrq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (EW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_tag     = mem_rdata[EW-1 -: TAG_BITS];
    assign rd_prio    = mem_rdata[RW +: PW];
    assign rd_retries = mem_rdata[RW-1:0];
    assign req_tag_m  = TAG_BITS'(request.request_tag);

    // zero acts as one, anything above the depth saturates
    always_comb
    begin
        eff_limit = CMPW'(qlim_reg);
        if (eff_limit == '0)
        begin
            eff_limit = CMPW'(1);
        end
        else if (eff_limit > CMPW'(QUEUE_DEPTH))
        begin
            eff_limit = CMPW'(QUEUE_DEPTH);
        end
    end

    assign at_limit = (CMPW'(count_reg) >= eff_limit) && (count_reg != '0);
    assign take     = rd_vld_reg && ((rd_lidx_reg == '0) || (rd_prio < min_prio_reg));
    assign out_load = (state_reg == bpdrq_pkg::S_DONE) && (!out_valid_reg || response.ready);

    assign request.ready = (state_reg == bpdrq_pkg::S_IDLE);

    assign response.valid            = out_valid_reg;
    assign response.event_res        = out_event_reg;
    assign response.item_tag         = out_tag_reg;
    assign response.evicted          = out_evicted_reg;
    assign response.evicted_tag      = out_ev_tag_reg;
    assign response.evicted_priority = out_ev_prio_reg;
    assign response.queue_count      = out_count_reg;
    assign response.connection_error = out_conn_reg;

    always_comb
    begin
        state_next          = state_reg;
        head_next           = head_reg;
        count_next          = count_reg;
        busy_next           = busy_reg;
        flight_tag_next     = flight_tag_reg;
        flight_prio_next    = flight_prio_reg;
        flight_retries_next = flight_retries_reg;
        qlim_next           = qlim_reg;
        rlim_next           = rlim_reg;
        ins_tag_next        = ins_tag_reg;
        ins_prio_next       = ins_prio_reg;
        ins_retries_next    = ins_retries_reg;
        idx_next            = idx_reg;
        rd_vld_next         = 1'b0;
        rd_lidx_next        = rd_lidx_reg;
        min_prio_next       = min_prio_reg;
        min_lidx_next       = min_lidx_reg;
        min_tag_next        = min_tag_reg;
        res_event_next      = res_event_reg;
        res_tag_next        = res_tag_reg;
        res_evicted_next    = res_evicted_reg;
        res_ev_tag_next     = res_ev_tag_reg;
        res_ev_prio_next    = res_ev_prio_reg;
        res_conn_next       = res_conn_reg;
        out_valid_next      = out_valid_reg && !response.ready;
        out_event_next      = out_event_reg;
        out_tag_next        = out_tag_reg;
        out_evicted_next    = out_evicted_reg;
        out_ev_tag_next     = out_ev_tag_reg;
        out_ev_prio_next    = out_ev_prio_reg;
        out_count_next      = out_count_reg;
        out_conn_next       = out_conn_reg;
        mem_we              = 1'b0;
        mem_waddr           = head_reg;
        mem_wdata           = {ins_tag_reg, ins_prio_reg, ins_retries_reg};
        mem_re              = 1'b0;
        mem_raddr           = head_reg;

        if (cfg_we && (cfg_index == bpdrq_pkg::CFG_QUEUE_LIMIT))
        begin
            qlim_next = cfg_data;
        end
        if (cfg_we && (cfg_index == bpdrq_pkg::CFG_RETRY_LIMIT))
        begin
            rlim_next = cfg_data[3:0];
        end

        case (state_reg)
            bpdrq_pkg::S_IDLE:
            begin
                if (request.valid)
                begin
                    res_tag_next     = '0;
                    res_evicted_next = 1'b0;
                    res_ev_tag_next  = '0;
                    res_ev_prio_next = '0;
                    res_conn_next    = 1'b0;
                    idx_next         = '0;
                    case (request.operation)
                        bpdrq_pkg::OP_ENQUEUE:
                        begin
                            res_event_next   = bpdrq_pkg::EV_QUEUED;
                            res_tag_next     = FTW'(req_tag_m);
                            ins_tag_next     = req_tag_m;
                            ins_prio_next    = request.request_priority;
                            ins_retries_next = request.retries_used;
                            state_next       = at_limit ? bpdrq_pkg::S_SCAN : bpdrq_pkg::S_APPEND;
                        end
                        bpdrq_pkg::OP_DISPATCH:
                        begin
                            if (busy_reg || (count_reg == '0))
                            begin
                                res_event_next = bpdrq_pkg::EV_NOTHING;
                                state_next     = bpdrq_pkg::S_DONE;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = head_reg;
                                state_next = bpdrq_pkg::S_FETCH;
                            end
                        end
                        bpdrq_pkg::OP_COMPLETE:
                        begin
                            if (busy_reg)
                            begin
                                busy_next    = 1'b0;
                                res_tag_next = FTW'(flight_tag_reg);
                                state_next   = bpdrq_pkg::S_DONE;
                                if (!request.failed)
                                begin
                                    res_event_next = bpdrq_pkg::EV_SUCCESS;
                                end
                                else
                                begin
                                    res_conn_next = request.refused;
                                    if (flight_retries_reg < rlim_reg)
                                    begin
                                        res_event_next   = bpdrq_pkg::EV_REQUEUED;
                                        ins_tag_next     = flight_tag_reg;
                                        ins_prio_next    = flight_prio_reg;
                                        ins_retries_next = flight_retries_reg + RW'(1);
                                        state_next       = at_limit ? bpdrq_pkg::S_SCAN
                                                                    : bpdrq_pkg::S_APPEND;
                                    end
                                    else
                                    begin
                                        res_event_next = bpdrq_pkg::EV_GAVE_UP;
                                    end
                                end
                            end
                            else
                            begin
                                res_event_next = bpdrq_pkg::EV_IGNORED;
                                state_next     = bpdrq_pkg::S_DONE;
                            end
                        end
                        default:
                        begin
                            res_event_next = bpdrq_pkg::EV_IGNORED;
                            state_next     = bpdrq_pkg::S_DONE;
                        end
                    endcase
                end
            end

            // one read per cycle, compare works on the registered read data
            bpdrq_pkg::S_SCAN:
            begin
                if (take)
                begin
                    min_prio_next = rd_prio;
                    min_lidx_next = rd_lidx_reg;
                    min_tag_next  = rd_tag;
                end
                if (idx_reg < count_reg)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = phys(head_reg, idx_reg);
                    idx_next     = idx_reg + CW'(1);
                    rd_vld_next  = 1'b1;
                    rd_lidx_next = idx_reg;
                end
                if (rd_vld_reg && (rd_lidx_reg == count_reg - CW'(1)))
                begin
                    res_evicted_next = 1'b1;
                    res_ev_tag_next  = FTW'(take ? rd_tag : min_tag_reg);
                    res_ev_prio_next = take ? rd_prio : min_prio_reg;
                    idx_next         = (take ? rd_lidx_reg : min_lidx_reg) + CW'(1);
                    rd_vld_next      = 1'b0;
                    state_next       = bpdrq_pkg::S_SHIFT;
                end
            end

            // close the gap: entry i+1 moves to slot i
            bpdrq_pkg::S_SHIFT:
            begin
                if (rd_vld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = phys(head_reg, rd_lidx_reg - CW'(1));
                    mem_wdata = mem_rdata;
                end
                if (idx_reg < count_reg)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = phys(head_reg, idx_reg);
                    idx_next     = idx_reg + CW'(1);
                    rd_vld_next  = 1'b1;
                    rd_lidx_next = idx_reg;
                end
                else if (!rd_vld_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = bpdrq_pkg::S_APPEND;
                end
            end

            bpdrq_pkg::S_APPEND:
            begin
                mem_we     = 1'b1;
                mem_waddr  = phys(head_reg, count_reg);
                mem_wdata  = {ins_tag_reg, ins_prio_reg, ins_retries_reg};
                count_next = count_reg + CW'(1);
                state_next = bpdrq_pkg::S_DONE;
            end

            bpdrq_pkg::S_FETCH:
            begin
                busy_next           = 1'b1;
                flight_tag_next     = rd_tag;
                flight_prio_next    = rd_prio;
                flight_retries_next = rd_retries;
                head_next           = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0
                                                                         : head_reg + AW'(1);
                count_next          = count_reg - CW'(1);
                res_event_next      = bpdrq_pkg::EV_DISPATCHED;
                res_tag_next        = FTW'(rd_tag);
                state_next          = bpdrq_pkg::S_DONE;
            end

            bpdrq_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next   = 1'b1;
                    out_event_next   = res_event_reg;
                    out_tag_next     = res_tag_reg;
                    out_evicted_next = res_evicted_reg;
                    out_ev_tag_next  = res_ev_tag_reg;
                    out_ev_prio_next = res_ev_prio_reg;
                    out_count_next   = 6'(count_reg);
                    out_conn_next    = res_conn_reg;
                    state_next       = bpdrq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bpdrq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= bpdrq_pkg::S_IDLE;
            head_reg           <= '0;
            count_reg          <= '0;
            busy_reg           <= 1'b0;
            flight_tag_reg     <= '0;
            flight_prio_reg    <= '0;
            flight_retries_reg <= '0;
            qlim_reg           <= bpdrq_pkg::QUEUE_LIMIT_RESET;
            rlim_reg           <= bpdrq_pkg::RETRY_LIMIT_RESET;
            rd_vld_reg         <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            head_reg           <= head_next;
            count_reg          <= count_next;
            busy_reg           <= busy_next;
            flight_tag_reg     <= flight_tag_next;
            flight_prio_reg    <= flight_prio_next;
            flight_retries_reg <= flight_retries_next;
            qlim_reg           <= qlim_next;
            rlim_reg           <= rlim_next;
            rd_vld_reg         <= rd_vld_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ins_tag_reg      <= ins_tag_next;
        ins_prio_reg     <= ins_prio_next;
        ins_retries_reg  <= ins_retries_next;
        idx_reg          <= idx_next;
        rd_lidx_reg      <= rd_lidx_next;
        min_prio_reg     <= min_prio_next;
        min_lidx_reg     <= min_lidx_next;
        min_tag_reg      <= min_tag_next;
        res_event_reg    <= res_event_next;
        res_tag_reg      <= res_tag_next;
        res_evicted_reg  <= res_evicted_next;
        res_ev_tag_reg   <= res_ev_tag_next;
        res_ev_prio_reg  <= res_ev_prio_next;
        res_conn_reg     <= res_conn_next;
        out_event_reg    <= out_event_next;
        out_tag_reg      <= out_tag_next;
        out_evicted_reg  <= out_evicted_next;
        out_ev_tag_reg   <= out_ev_tag_next;
        out_ev_prio_reg  <= out_ev_prio_next;
        out_count_reg    <= out_count_next;
        out_conn_reg     <= out_conn_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bpdrq_pkg::S_APPEND |-> count_reg < CW'(QUEUE_DEPTH))
        else $error("append into a full queue");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bpdrq_pkg::S_SCAN |-> count_reg != '0)
        else $error("eviction scan over an empty queue");

    a_dispatch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && res_event_reg == bpdrq_pkg::EV_DISPATCHED |-> busy_reg)
        else $error("dispatch reported without an item in flight");

endmodule

FILE: bench/bpdrq_queue_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// bpdrq_queue_checker
// Watches the request, response and register ports of the bounded priority
// drop/retry queue, keeps its own copy of the queue, the in-flight slot and
// the limits, works out the event due for every accepted request and compares
// it field by field with the responses in order.
// ============================================================================
module bpdrq_queue_checker
    import bpdrq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    bpdrq_req_if                    request,
    bpdrq_rsp_if                    response,
    output int                      fail_count,
    output int                      pending
);

    localparam int QDEPTH = DEPTH_DEFAULT;

    typedef struct packed {
        event_t                     ev;
        logic [FIELD_TAG_W-1:0]     tag;
        logic                       evicted;
        logic [FIELD_TAG_W-1:0]     ev_tag;
        logic signed [PRIO_W-1:0]   ev_prio;
        logic [QCOUNT_W-1:0]        count;
        logic                       conn_err;
    } outcome_t;

    outcome_t expected_events [$];

    // model of the queue contents, in FIFO order from slot 0
    logic [FIELD_TAG_W-1:0]     slot_tag   [QDEPTH];
    logic signed [PRIO_W-1:0]   slot_prio  [QDEPTH];
    logic [RETRY_W-1:0]         slot_tries [QDEPTH];
    int                         n_queued;
    logic                       in_flight;
    logic [FIELD_TAG_W-1:0]     fl_tag;
    logic signed [PRIO_W-1:0]   fl_prio;
    logic [RETRY_W-1:0]         fl_tries;
    logic [5:0]                 q_limit;
    logic [3:0]                 r_limit;

    function automatic void push_with_eviction(
        input  logic [FIELD_TAG_W-1:0]   tag,
        input  logic signed [PRIO_W-1:0] prio,
        input  logic [RETRY_W-1:0]       tries,
        inout  outcome_t                 o
    );
        int lim;
        int victim;
        lim = (q_limit == 0) ? 1 : ((q_limit > QDEPTH) ? QDEPTH : int'(q_limit));
        if (n_queued >= lim && n_queued > 0)
        begin
            // the earliest entry is evicted on a priority tie
            victim = 0;
            for (int i = 1; i < n_queued; i++)
                if (slot_prio[i] < slot_prio[victim])
                    victim = i;
            o.evicted = 1'b1;
            o.ev_tag  = slot_tag[victim];
            o.ev_prio = slot_prio[victim];
            for (int i = victim; i + 1 < n_queued; i++)
            begin
                slot_tag[i]   = slot_tag[i + 1];
                slot_prio[i]  = slot_prio[i + 1];
                slot_tries[i] = slot_tries[i + 1];
            end
            n_queued--;
        end
        if (n_queued < QDEPTH)
        begin
            slot_tag[n_queued]   = tag;
            slot_prio[n_queued]  = prio;
            slot_tries[n_queued] = tries;
            n_queued++;
        end
    endfunction

    function automatic outcome_t predict_outcome(
        input logic [OP_W-1:0]          op,
        input logic [FIELD_TAG_W-1:0]   tag,
        input logic signed [PRIO_W-1:0] prio,
        input logic [RETRY_W-1:0]       tries,
        input logic                     is_failed,
        input logic                     is_refused
    );
        outcome_t o;
        o = '0;
        case (op)
            OP_ENQUEUE:
            begin
                push_with_eviction(tag, prio, tries, o);
                o.ev  = EV_QUEUED;
                o.tag = tag;
            end
            OP_DISPATCH:
            begin
                if (in_flight || n_queued == 0)
                    o.ev = EV_NOTHING;
                else
                begin
                    in_flight = 1'b1;
                    fl_tag    = slot_tag[0];
                    fl_prio   = slot_prio[0];
                    fl_tries  = slot_tries[0];
                    for (int i = 0; i + 1 < n_queued; i++)
                    begin
                        slot_tag[i]   = slot_tag[i + 1];
                        slot_prio[i]  = slot_prio[i + 1];
                        slot_tries[i] = slot_tries[i + 1];
                    end
                    n_queued--;
                    o.ev  = EV_DISPATCHED;
                    o.tag = fl_tag;
                end
            end
            OP_COMPLETE:
            begin
                if (!in_flight)
                    o.ev = EV_IGNORED;
                else
                begin
                    o.tag = fl_tag;
                    if (is_failed)
                    begin
                        o.conn_err = is_refused;
                        if (fl_tries < r_limit)
                        begin
                            push_with_eviction(fl_tag, fl_prio, fl_tries + 4'd1, o);
                            o.ev = EV_REQUEUED;
                        end
                        else
                            o.ev = EV_GAVE_UP;
                    end
                    else
                        o.ev = EV_SUCCESS;
                    in_flight = 1'b0;
                end
            end
            default:
                o.ev = EV_IGNORED;
        endcase
        o.count = QCOUNT_W'(n_queued);
        return o;
    endfunction

    task automatic field_check(input string fname, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        outcome_t want;
        outcome_t got;
        if (!rst_n)
        begin
            expected_events.delete();
            n_queued   = 0;
            in_flight  = 1'b0;
            fl_tag     = '0;
            fl_prio    = '0;
            fl_tries   = '0;
            q_limit    = QUEUE_LIMIT_RESET;
            r_limit    = RETRY_LIMIT_RESET;
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_QUEUE_LIMIT: q_limit = cfg_data;
                    CFG_RETRY_LIMIT: r_limit = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (request.valid && request.ready)
                expected_events.push_back(predict_outcome(request.operation,
                    request.request_tag, request.request_priority, request.retries_used,
                    request.failed, request.refused));
            if (response.valid && response.ready)
            begin
                got.ev       = event_t'(response.event_res);
                got.tag      = response.item_tag;
                got.evicted  = response.evicted;
                got.ev_tag   = response.evicted_tag;
                got.ev_prio  = response.evicted_priority;
                got.count    = response.queue_count;
                got.conn_err = response.connection_error;
                if (expected_events.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, actual event %0d tag %h",
                             $time, got.ev, got.tag);
                    fail_count++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    field_check("event_res", int'(want.ev), int'(got.ev));
                    field_check("item_tag", int'(want.tag), int'(got.tag));
                    field_check("evicted", int'(want.evicted), int'(got.evicted));
                    field_check("evicted_tag", int'(want.ev_tag), int'(got.ev_tag));
                    field_check("evicted_priority", int'(want.ev_prio), int'(got.ev_prio));
                    field_check("queue_count", int'(want.count), int'(got.count));
                    field_check("connection_error", int'(want.conn_err),
                                int'(got.conn_err));
                end
            end
            pending = expected_events.size();
        end
    end

endmodule

FILE: bench/tb_bounded_priority_drop_retry_queue.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_bounded_priority_drop_retry_queue
// Drives the queue with a directed sequence (idle completions, empty and
// busy ticks, extreme fields, requeue, give-up, priority ties, limit zero,
// a lowered limit below the count) and then random phases under changing
// limits, with random gaps and stalls on both channels and long receiver
// hold-offs. The checker beside the block flags every wrong event.
// ============================================================================
module tb_bounded_priority_drop_retry_queue;
    import bpdrq_pkg::*;

    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int SETTLE_CYCLES   = 2 * DEPTH_DEFAULT + 16;
    localparam int RAND_PHASES     = 10;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int HOLD_CYCLES     = 400;
    localparam logic [5:0] QLIMITS [RAND_PHASES] = '{1, 63, 4, 32, 0, 7, 20, 2, 33, 12};
    localparam logic [3:0] RLIMITS [RAND_PHASES] = '{0, 15, 3, 1, 15, 2, 0, 7, 5, 9};

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     fail_count;
    int                     pending;
    int                     cycle_count = 0;
    int                     hold_requests = 0;
    bit                     sender_calm = 1'b0;

    bpdrq_req_if request ();
    bpdrq_rsp_if response ();

    bounded_priority_drop_retry_queue u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request),
        .response  (response)
    );

    bpdrq_queue_checker u_queue_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .request    (request),
        .response   (response),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("bounded_priority_drop_retry_queue test failed");
            $finish;
        end
    end

    // receiver: random stalls, calm stretches, and long hold-offs on request
    initial
    begin : sink_side
        int stall_left;
        int calm_left;
        int hold_left;
        int holds_seen;
        int roll;
        stall_left = 0;
        calm_left  = 0;
        hold_left  = 0;
        holds_seen = 0;
        response.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_seen)
            begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                response.ready <= 1'b0;
                hold_left--;
            end
            else if (calm_left > 0)
            begin
                response.ready <= 1'b1;
                calm_left--;
            end
            else if (stall_left > 0)
            begin
                response.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 6)
                begin
                    calm_left = $urandom_range(20, 100);
                    response.ready <= 1'b1;
                end
                else if (roll < 50)
                    response.ready <= 1'b1;
                else
                begin
                    if (roll < 86)
                        stall_left = $urandom_range(0, 2);
                    else if (roll < 97)
                        stall_left = $urandom_range(3, 10);
                    else
                        stall_left = $urandom_range(20, 60);
                    response.ready <= 1'b0;
                end
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (sender_calm || roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(
        input logic [OP_W-1:0]        op,
        input logic [FIELD_TAG_W-1:0] tag,
        input logic [PRIO_W-1:0]      prio,
        input logic [RETRY_W-1:0]     tries,
        input logic                   is_failed,
        input logic                   is_refused
    );
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            request.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        request.valid            <= 1'b1;
        request.operation        <= op;
        request.request_tag      <= tag;
        request.request_priority <= prio;
        request.retries_used     <= tries;
        request.failed           <= is_failed;
        request.refused          <= is_refused;
        do
            @(posedge clk);
        while (!request.ready);
    endtask

    task automatic random_item(input int enq_pct);
        int roll;
        logic [OP_W-1:0]   op;
        logic [PRIO_W-1:0] prio;
        logic [RETRY_W-1:0] tries;
        roll = $urandom_range(0, 99);
        if (roll < enq_pct)
            op = OP_ENQUEUE;
        else if (roll < enq_pct + (100 - enq_pct) / 2 - 2)
            op = OP_DISPATCH;
        else if (roll < 97)
            op = OP_COMPLETE;
        else
            op = OP_RESERVED;
        // narrow priorities half of the time so ties happen
        roll = $urandom_range(0, 9);
        if (roll < 5)
            prio = PRIO_W'($urandom_range(0, 6) - 3);
        else if (roll < 8)
            prio = PRIO_W'($urandom);
        else if (roll == 8)
            prio = 16'h8000;
        else
            prio = 16'h7FFF;
        if ($urandom_range(0, 3) == 0)
            tries = RETRY_W'($urandom_range(0, 15));
        else
            tries = RETRY_W'($urandom_range(0, 2));
        send_item(op, FIELD_TAG_W'($urandom), prio, tries,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // all results in, then give any pending work time to settle
    task automatic wait_quiet();
        @(negedge clk);
        request.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_limits(input logic [5:0] qlim, input logic [3:0] rlim);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_QUEUE_LIMIT;
        cfg_data  <= qlim;
        @(negedge clk);
        cfg_index <= CFG_RETRY_LIMIT;
        cfg_data  <= CFG_DATA_W'(rlim);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_QUEUE_LIMIT;
        cfg_data  = '0;
        request.valid            = 1'b0;
        request.operation        = OP_ENQUEUE;
        request.request_tag      = '0;
        request.request_priority = '0;
        request.retries_used     = '0;
        request.failed           = 1'b0;
        request.refused          = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset limits: idle completions, empty tick, extremes, retry paths
        send_item(OP_COMPLETE, 16'hFFFF, 16'h7FFF, 4'hF, 1'b1, 1'b1);
        send_item(OP_RESERVED, 16'h5555, 16'h8000, 4'h0, 1'b0, 1'b0);
        send_item(OP_DISPATCH, 16'h0000, 16'h0000, 4'h0, 1'b0, 1'b0);
        send_item(OP_ENQUEUE, 16'h0000, 16'h8000, 4'h0, 1'b0, 1'b0);
        send_item(OP_ENQUEUE, 16'hFFFF, 16'h7FFF, 4'hF, 1'b1, 1'b1);
        send_item(OP_ENQUEUE, 16'h1234, 16'h0000, 4'h5, 1'b0, 1'b0);
        send_item(OP_DISPATCH, 16'h0000, 16'h0000, 4'h0, 1'b0, 1'b0);
        send_item(OP_DISPATCH, 16'h0000, 16'h0000, 4'h0, 1'b0, 1'b0);
        send_item(OP_COMPLETE, 16'h0000, 16'h0000, 4'h0, 1'b1, 1'b1);
        send_item(OP_DISPATCH, 16'h0000, 16'h0000, 4'h0, 1'b0, 1'b0);
        send_item(OP_COMPLETE, 16'h0000, 16'h0000, 4'h0, 1'b1, 1'b0);
        send_item(OP_DISPATCH, 16'h0000, 16'h0000, 4'h0, 1'b0, 1'b0);
        send_item(OP_COMPLETE, 16'h0000, 16'h0000, 4'h0, 1'b0, 1'b1);

        // zero queue limit acts as one; zero retries gives up at once
        set_limits(6'd0, 4'd0);
        send_item(OP_ENQUEUE, 16'h000A, 16'h0005, 4'h0, 1'b0, 1'b0);
        send_item(OP_DISPATCH, 16'h0000, 16'h0000, 4'h0, 1'b0, 1'b0);
        send_item(OP_ENQUEUE, 16'h000B, 16'h0007, 4'h0, 1'b0, 1'b0);
        send_item(OP_COMPLETE, 16'h0000, 16'h0000, 4'h0, 1'b1, 1'b0);

        // priority ties: the earliest of the lowest goes
        set_limits(6'd4, 4'd15);
        send_item(OP_ENQUEUE, 16'h00C0, 16'h0003, 4'h0, 1'b0, 1'b0);
        send_item(OP_ENQUEUE, 16'h00C1, 16'h0001, 4'h0, 1'b0, 1'b0);
        send_item(OP_ENQUEUE, 16'h00C2, 16'h0001, 4'h0, 1'b0, 1'b0);
        send_item(OP_ENQUEUE, 16'h00C3, 16'h0002, 4'h0, 1'b0, 1'b0);
        send_item(OP_ENQUEUE, 16'h00C4, 16'h0009, 4'h0, 1'b0, 1'b0);

        // limit lowered below the count: one eviction per insert, no trim
        set_limits(6'd2, 4'd15);
        send_item(OP_ENQUEUE, 16'h00C5, 16'hFFFF, 4'h0, 1'b0, 1'b0);
        send_item(OP_DISPATCH, 16'h0000, 16'h0000, 4'h0, 1'b0, 1'b0);
        send_item(OP_COMPLETE, 16'h0000, 16'h0000, 4'h0, 1'b1, 1'b1);

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            set_limits(QLIMITS[p], RLIMITS[p]);
            sender_calm = (p % 4 == 3);
            if (p == 1 || p == 6)
                hold_requests = hold_requests + 1;
            repeat (ITEMS_PER_PHASE)
                random_item((QLIMITS[p] >= 20) ? 70 : 45);
        end

        wait_quiet();
        if (fail_count == 0 && pending == 0)
            $display("bounded_priority_drop_retry_queue test passed");
        else
            $display("bounded_priority_drop_retry_queue test failed");
        $finish;
    end

endmodule

FILE: sim.f
sv/bpdrq_pkg.sv
sv/bpdrq_req_if.sv
sv/bpdrq_rsp_if.sv
sv/bpdrq_mem.sv
sv/bounded_priority_drop_retry_queue.sv
bench/bpdrq_queue_checker.sv
bench/tb_bounded_priority_drop_retry_queue.sv
